[rtl/prefixed_integer_text_parser_core_macros.svh]
// Assertion macros shared by the parser checker.
`ifndef PREFIXED_INTEGER_TEXT_PARSER_CORE_MACROS_SVH
`define PREFIXED_INTEGER_TEXT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("parser check failed in the same cycle");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("parser check failed in the next cycle");

`endif

[rtl/pitp_pkg.sv]
// Shared types, codes and digit decoding for the integer text parser.
`default_nettype none

package pitp_pkg;

    localparam int CH_W    = 8;
    localparam int ACC_W   = 64;
    localparam int HALF_W  = 32;
    localparam int DIGIT_W = 4;

    // parse phase codes
    localparam logic [1:0] PH_WS     = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    // base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    // configuration register indexes
    localparam logic REG_SIGNED_MODE = 1'b0;
    localparam logic REG_WIDE_MODE   = 1'b1;

    // character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CH_W-1:0] CH_EIGHT = 8'h38;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [1:0]       phase;
        logic             neg_seen;
        logic [1:0]       base_code;
        logic [ACC_W-1:0] accum;
        logic             bad_seen;
    } t_state;

    localparam t_state ST_CLEAR = '{
        phase:     PH_WS,
        neg_seen:  1'b0,
        base_code: BASE_DEC,
        accum:     '0,
        bad_seen:  1'b0
    };

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ok;
    } t_result;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } t_digit;

    // Decode one character as a digit of the given base.
    function automatic t_digit digit_decode(input logic [1:0] base, input logic [CH_W-1:0] ch);
        t_digit d;
        logic [CH_W-1:0] diff;
        d = '{ok: 1'b0, val: '0};
        diff = '0;
        case (ch) inside
            [CH_ZERO:CH_SEVEN]: begin
                diff = ch - CH_ZERO;
                d = '{ok: 1'b1, val: diff[DIGIT_W-1:0]};
            end
            [CH_EIGHT:CH_NINE]: begin
                diff = ch - CH_ZERO;
                d = '{ok: (base != BASE_OCT), val: diff[DIGIT_W-1:0]};
            end
            [CH_LA:CH_LF]: begin
                diff = ch - CH_LA + 8'd10;
                d = '{ok: (base == BASE_HEX), val: diff[DIGIT_W-1:0]};
            end
            [CH_UA:CH_UF]: begin
                diff = ch - CH_UA + 8'd10;
                d = '{ok: (base == BASE_HEX), val: diff[DIGIT_W-1:0]};
            end
            default: begin
                d = '{ok: 1'b0, val: '0};
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/pitp_step.sv]
// Next-state and result logic for one character of the parser.
`default_nettype none

module pitp_step import pitp_pkg::*; (
    input  t_state          i_state,
    input  logic [CH_W-1:0] i_ch,
    input  logic            i_signed_mode,
    input  logic            i_wide_mode,
    output t_state          o_state,
    output t_result         o_result
);

    logic [1:0]       eff_base;
    logic             do_take;
    t_digit           digit;
    logic [ACC_W-1:0] scaled;
    logic [ACC_W-1:0] signed_val;

    // base that a digit taken by this character is checked against
    always_comb begin
        case (i_state.phase)
            PH_WS, PH_SIGN: eff_base = BASE_DEC;
            PH_ZERO:        eff_base = BASE_OCT;
            default:        eff_base = i_state.base_code;
        endcase
    end

    assign digit = digit_decode(eff_base, i_ch);

    always_comb begin
        case (eff_base)
            BASE_HEX: scaled = i_state.accum << 4;
            BASE_OCT: scaled = i_state.accum << 3;
            default:  scaled = (i_state.accum << 3) + (i_state.accum << 1);
        endcase
    end

    // result at the terminator
    always_comb begin
        signed_val = i_state.neg_seen ? (ACC_W'(0) - i_state.accum) : i_state.accum;
        if (!i_wide_mode) begin
            signed_val[ACC_W-1:HALF_W] = '0;
        end
        o_result.ok    = !i_state.bad_seen;
        o_result.value = i_state.bad_seen ? '0 : signed_val;
    end

    always_comb begin
        o_state = i_state;
        do_take = 1'b0;
        if (i_ch == CH_NUL) begin
            o_state = ST_CLEAR;
        end else begin
            case (i_state.phase)
                PH_WS, PH_SIGN: begin
                    if (i_state.phase == PH_WS && (i_ch == CH_SPACE || i_ch == CH_TAB)) begin
                        o_state.phase = PH_WS;
                    end else if (i_state.phase == PH_WS && i_ch == CH_MINUS
                                 && i_signed_mode) begin
                        o_state.neg_seen = 1'b1;
                        o_state.phase    = PH_SIGN;
                    end else if (i_ch == CH_ZERO) begin
                        o_state.base_code = BASE_OCT;
                        o_state.phase     = PH_ZERO;
                    end else begin
                        o_state.base_code = BASE_DEC;
                        o_state.phase     = PH_DIGITS;
                        do_take           = 1'b1;
                    end
                end
                PH_ZERO: begin
                    o_state.phase = PH_DIGITS;
                    if (i_ch == CH_LX || i_ch == CH_UX) begin
                        o_state.base_code = BASE_HEX;
                    end else begin
                        o_state.base_code = BASE_OCT;
                        do_take           = 1'b1;
                    end
                end
                default: begin
                    do_take = 1'b1;
                end
            endcase
            // once bad, hold the accumulator until the terminator
            if (do_take && !i_state.bad_seen) begin
                if (digit.ok) begin
                    o_state.accum = scaled + ACC_W'(digit.val);
                end else begin
                    o_state.bad_seen = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/prefixed_integer_text_parser_core.sv]
// Streaming parser of C-style integer literals, one character per transaction.
//
// Input: s_axis carries one character per transaction in tdata; a code of 0
// ends the string. Leading spaces and tabs are skipped, one '-' is taken in
// signed mode, a leading 0 selects octal and 0x/0X hexadecimal.
// Output: one transaction per terminator on m_axis, tdata holding the value
// (upper 32 bits zero in 32-bit mode) and tuser the ok flag; a string with an
// invalid character gives value 0 and ok 0.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 signed_mode,
// 1 wide_mode); write only while no string is in flight.
// Throughput: one character per cycle while no terminator waits on a held
// result. Every character passes an input register and the next-state logic
// (shift-and-add of the accumulator); the terminator's result is then
// registered in the output register.
// Reset: synchronous, active low; clears the parse state and the valid flags
// of both pipeline registers, and sets signed_mode to 1 and wide_mode to 0.
// Stall: a held result stops a terminator in the input register and all input
// behind it; ordinary characters before it flow while m_axis_tready is low.
`default_nettype none

module prefixed_integer_text_parser_core import pitp_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [CH_W-1:0]  s_axis_tdata,   // [7:0] ch
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [ACC_W-1:0] m_axis_tdata,   // [63:0] value
    output logic             m_axis_tuser,   // [0] ok
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire              i_cfg_data
);

    logic             r_signed_mode;
    logic             r_wide_mode;
    logic             r_in_valid;
    logic [CH_W-1:0]  r_ch;
    t_state           r_st;
    t_state           n_st;
    t_result          n_res;
    logic             r_out_valid;
    t_result          r_out;
    logic             w_is_term;
    logic             w_adv;

    pitp_step u_step (
        .i_state       (r_st),
        .i_ch          (r_ch),
        .i_signed_mode (r_signed_mode),
        .i_wide_mode   (r_wide_mode),
        .o_state       (n_st),
        .o_result      (n_res)
    );

    assign w_is_term     = (r_ch == CH_NUL);
    // a terminator advances only into a free output register
    assign w_adv         = r_in_valid && (!w_is_term || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_wide_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIGNED_MODE: r_signed_mode <= i_cfg_data;
                REG_WIDE_MODE:   r_wide_mode   <= i_cfg_data;
                default:         r_wide_mode   <= r_wide_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_ch <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
        end else if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_term) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_term) begin
            r_out <= n_res;
        end
    end

endmodule

`default_nettype wire

[rtl/pitp_checker.sv]
// Port-level checks on the parser, bound to the top level.
`default_nettype none
`include "prefixed_integer_text_parser_core_macros.svh"

module pitp_checker import pitp_pkg::*; (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             s_axis_tready,
    input wire             m_axis_tvalid,
    input wire             m_axis_tready,
    input wire [ACC_W-1:0] m_axis_tdata,
    input wire             m_axis_tuser
);

    // a failed parse always reports a zero value
    `PITP_ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

    // with the output free, the input side never stalls
    `PITP_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    // a stalled result stays
    `PITP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    `PITP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind prefixed_integer_text_parser_core pitp_checker u_pitp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
